[sv/assert_macros.svh]
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/tgrm_pkg.sv]
// Types, widths, codes and the tilt limiter of the gimbal rate mixer.
package tgrm_pkg;

    localparam int CMD_W      = 14;
    localparam int RATE_W     = 16;
    localparam int TILT_W     = 16;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    // Rounded axis term: 3 integer coefficient bits, rate width, one carry bit.
    localparam int TERM_W     = RATE_W + 4;
    localparam int MIX_W      = TERM_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT = 1'd1;

    localparam logic [LIM_W-1:0] TILT_LIMIT_RST = 15'h7FFF;

    localparam logic signed [MIX_W-1:0] TILT_MAX = MIX_W'(32767);
    localparam logic signed [MIX_W-1:0] TILT_MIN = -MIX_W'(32768);
    localparam logic signed [TILT_W-1:0] TILT_MOST_NEG = 16'sh8000;

    typedef enum logic {
        MODE_FIRST = 1'b0,
        MODE_UPPER = 1'b1
    } t_stage_mode;

    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_SAME = 2'd1,
        CHK_OPP  = 2'd2
    } t_chk;

    typedef struct packed {
        logic signed [TILT_W-1:0] tilt;
        logic                     clip;
    } t_tilt_res;

    function automatic t_tilt_res limit_tilt(
        input logic signed [MIX_W-1:0] v,
        input t_stage_mode             mode,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [MIX_W-1:0] s;
        logic signed [MIX_W-1:0] lim_s;
        t_tilt_res               res;
        res.clip = 1'b0;
        s        = v;
        lim_s    = $signed({{(MIX_W-LIM_W){1'b0}}, lim});
        if (v > TILT_MAX) begin
            s        = TILT_MAX;
            res.clip = 1'b1;
        end else if (v < TILT_MIN) begin
            s        = TILT_MIN;
            res.clip = 1'b1;
        end
        if (mode == MODE_UPPER) begin
            if (s > lim_s) begin
                s        = lim_s;
                res.clip = 1'b1;
            end else if (s < -lim_s) begin
                s        = -lim_s;
                res.clip = 1'b1;
            end
        end
        res.tilt = s[TILT_W-1:0];
        return res;
    endfunction

endpackage

[sv/thrust_gimbal_rate_mixer_core.sv]
// Thrust gimbal rate mixer: four-stage pipeline from axis commands to engine tilts.
//
// One sample set is taken every cycle while o_in_ready is high. Its tilts pass through
// the stage one to stage four registers and are presented from the stage four register.
// Stage one picks each axis's coefficients (command sign, rate sign, sign check,
// damping). Stage two holds the two constant multiplies per axis. Stage three rounds
// each axis term. Stage four mixes the engine tilts, saturates, applies the
// upper-stage clamp and holds the result. A stalled output holds only the run of full
// stages behind it; empty stages keep taking transfers until all four are full.
// The user must write stage_mode and tilt_limit only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module thrust_gimbal_rate_mixer_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tgrm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tgrm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [tgrm_pkg::CMD_W-1:0]    i_roll_cmd,
    input  logic signed [tgrm_pkg::CMD_W-1:0]    i_pitch_cmd,
    input  logic signed [tgrm_pkg::CMD_W-1:0]    i_yaw_cmd,
    input  logic signed [tgrm_pkg::RATE_W-1:0]   i_roll_rate,
    input  logic signed [tgrm_pkg::RATE_W-1:0]   i_pitch_rate,
    input  logic signed [tgrm_pkg::RATE_W-1:0]   i_yaw_rate,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [tgrm_pkg::TILT_W-1:0]   o_side_tilt,
    output logic signed [tgrm_pkg::TILT_W-1:0]   o_engine_one_tilt,
    output logic signed [tgrm_pkg::TILT_W-1:0]   o_engine_two_tilt,
    output logic signed [tgrm_pkg::TILT_W-1:0]   o_engine_three_tilt,
    output logic signed [tgrm_pkg::TILT_W-1:0]   o_engine_four_tilt,
    output logic                                 o_clipped
);
    import tgrm_pkg::*;

    localparam int CB  = FRAC_BITS + 4;
    localparam int CW  = CB + 3;
    localparam int PCW = CW + CMD_W;
    localparam int PW  = CW + RATE_W;
    localparam int AW  = PW + 1;

    localparam longint ONE = 64'sd1 <<< CB;

    localparam logic signed [CW-1:0] G_3_5    = CW'((3 * ONE + 2) / 5);
    localparam logic signed [CW-1:0] G_9_100  = CW'((9 * ONE + 50) / 100);
    localparam logic signed [CW-1:0] K_24_7   = CW'((24 * ONE + 3) / 7);
    localparam logic signed [CW-1:0] K_18_35  = CW'((18 * ONE + 17) / 35);
    localparam logic signed [CW-1:0] K_9_35   = CW'((9 * ONE + 17) / 35);
    localparam logic signed [CW-1:0] D_12_5   = CW'((12 * ONE + 2) / 5);
    localparam logic signed [CW-1:0] D_57_20  = CW'((57 * ONE + 10) / 20);
    localparam logic signed [CW-1:0] D_19_10  = CW'((19 * ONE + 5) / 10);
    localparam logic signed [CW-1:0] D_99_50  = CW'((99 * ONE + 25) / 50);

    localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< (CB - 1));

    // config
    t_stage_mode       r_stage_mode;
    logic [LIM_W-1:0]  r_tilt_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_mode <= MODE_FIRST;
            r_tilt_limit <= TILT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STAGE_MODE: r_stage_mode <= t_stage_mode'(i_cfg_data[0]);
                CFG_TILT_LIMIT: r_tilt_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic r1_vld, r2_vld, r3_vld, r4_vld;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r4_vld || i_out_ready;
    assign rdy3 = !r3_vld || rdy4;
    assign rdy2 = !r2_vld || rdy3;
    assign rdy1 = !r1_vld || rdy2;

    assign o_in_ready  = rdy1;
    assign o_out_valid = r4_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= i_in_valid;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
            if (rdy4) r4_vld <= r3_vld;
        end
    end

    // stage 1: coefficient select; axis 0 roll, 1 pitch, 2 yaw
    logic signed [CMD_W-1:0]  in_c [3];
    logic signed [RATE_W-1:0] in_w [3];
    logic signed [CW-1:0]     sel_g  [3];
    logic signed [CW-1:0]     sel_gk [3];
    logic signed [CW-1:0]     sel_d  [3];
    t_chk                     sel_chk [3];
    logic signed [CW-1:0]     n1_m [3];

    assign in_c[0] = i_roll_cmd;
    assign in_c[1] = i_pitch_cmd;
    assign in_c[2] = i_yaw_cmd;
    assign in_w[0] = i_roll_rate;
    assign in_w[1] = i_pitch_rate;
    assign in_w[2] = i_yaw_rate;

    always_comb begin
        sel_g[1]   = G_9_100;
        sel_gk[1]  = K_18_35;
        sel_chk[1] = CHK_SAME;
        sel_g[2]   = G_9_100;
        sel_gk[2]  = K_18_35;
        sel_chk[2] = CHK_OPP;
        if (r_stage_mode == MODE_UPPER) begin
            sel_g[0]   = G_9_100;
            sel_gk[0]  = K_9_35;
            sel_d[0]   = D_99_50;
            sel_chk[0] = CHK_NONE;
            sel_d[1]   = D_19_10;
            sel_d[2]   = -D_19_10;
        end else begin
            sel_g[0]   = G_3_5;
            sel_gk[0]  = K_24_7;
            sel_d[0]   = D_57_20;
            sel_chk[0] = CHK_SAME;
            sel_d[1]   = D_12_5;
            sel_d[2]   = -D_12_5;
        end
    end

    // term = g*c + m*w, with m the damping, zero (full command) or -sign(c)*sign(w)*g/k
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic c_neg, w_neg, w_pos, full;
            c_neg = in_c[i][CMD_W-1];
            w_neg = in_w[i][RATE_W-1];
            w_pos = !w_neg && (in_w[i] != '0);
            case (sel_chk[i])
                CHK_SAME: full = (!c_neg && w_pos) || (c_neg && w_neg);
                CHK_OPP:  full = (!c_neg && w_neg) || (c_neg && w_pos);
                default:  full = 1'b0;
            endcase
            if (in_c[i] == '0) begin
                n1_m[i] = sel_d[i];
            end else if (full) begin
                n1_m[i] = '0;
            end else if (c_neg == w_neg) begin
                n1_m[i] = -sel_gk[i];
            end else begin
                n1_m[i] = sel_gk[i];
            end
        end
    end

    logic signed [CMD_W-1:0]  r1_c [3];
    logic signed [RATE_W-1:0] r1_w [3];
    logic signed [CW-1:0]     r1_g [3];
    logic signed [CW-1:0]     r1_m [3];
    t_stage_mode              r1_mode;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            for (int i = 0; i < 3; i++) begin
                r1_c[i] <= in_c[i];
                r1_w[i] <= in_w[i];
                r1_g[i] <= sel_g[i];
                r1_m[i] <= n1_m[i];
            end
            r1_mode <= r_stage_mode;
        end
    end

    // stage 2: products
    logic signed [PCW-1:0] r2_pc [3];
    logic signed [PW-1:0]  r2_pw [3];
    t_stage_mode           r2_mode;

    always_ff @(posedge i_clk) begin
        if (rdy2 && r1_vld) begin
            for (int i = 0; i < 3; i++) begin
                r2_pc[i] <= PCW'(r1_g[i]) * PCW'(r1_c[i]);
                r2_pw[i] <= PW'(r1_m[i]) * PW'(r1_w[i]);
            end
            r2_mode <= r1_mode;
        end
    end

    // stage 3: sum products, round to nearest, half up
    logic signed [AW-1:0]     n3_acc [3];
    logic signed [TERM_W-1:0] r3_t [3];
    t_stage_mode              r3_mode;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_acc[i] = AW'(r2_pc[i]) + AW'(r2_pw[i]) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r2_vld) begin
            for (int i = 0; i < 3; i++) begin
                r3_t[i] <= $signed(n3_acc[i][AW-1:CB]);
            end
            r3_mode <= r2_mode;
        end
    end

    // stage 4: mix, saturate, clamp
    logic signed [MIX_W-1:0] p_plus_r, p_minus_r;
    t_tilt_res               lim_side, lim_e1, lim_e2, lim_e3, lim_e4;

    assign p_plus_r  = MIX_W'(r3_t[1]) + MIX_W'(r3_t[0]);
    assign p_minus_r = MIX_W'(r3_t[1]) - MIX_W'(r3_t[0]);

    always_comb begin
        lim_side = limit_tilt(MIX_W'(r3_t[2]), r3_mode, r_tilt_limit);
        lim_e3   = limit_tilt(p_minus_r, r3_mode, r_tilt_limit);
        lim_e4   = limit_tilt(p_plus_r, r3_mode, r_tilt_limit);
        if (r3_mode == MODE_UPPER) begin
            lim_e1 = limit_tilt(p_minus_r, r3_mode, r_tilt_limit);
            lim_e2 = limit_tilt(p_plus_r, r3_mode, r_tilt_limit);
        end else begin
            lim_e1 = limit_tilt(p_plus_r, r3_mode, r_tilt_limit);
            lim_e2 = limit_tilt(p_minus_r, r3_mode, r_tilt_limit);
        end
    end

    t_stage_mode r4_mode;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r3_vld) begin
            o_side_tilt         <= lim_side.tilt;
            o_engine_one_tilt   <= lim_e1.tilt;
            o_engine_two_tilt   <= lim_e2.tilt;
            o_engine_three_tilt <= lim_e3.tilt;
            o_engine_four_tilt  <= lim_e4.tilt;
            o_clipped           <= lim_side.clip | lim_e1.clip | lim_e2.clip |
                                   lim_e3.clip | lim_e4.clip;
            r4_mode             <= r3_mode;
        end
    end

    `ASSERT_IMPLIES(a_ready_when_drained, i_clk, i_rst_n, i_out_ready, o_in_ready, "input stalled while output drains")
    `ASSERT_IMPLIES(a_upper_clamp_sym, i_clk, i_rst_n, o_out_valid && (r4_mode == MODE_UPPER), (o_side_tilt != TILT_MOST_NEG) && (o_engine_one_tilt != TILT_MOST_NEG) && (o_engine_two_tilt != TILT_MOST_NEG) && (o_engine_three_tilt != TILT_MOST_NEG) && (o_engine_four_tilt != TILT_MOST_NEG), "upper stage tilt outside symmetric clamp")
    `ASSERT_NEXT(a_stage3_holds, i_clk, i_rst_n, r3_vld && r4_vld && !i_out_ready, r3_vld && $stable(r3_t[1]) && $stable(r3_t[0]), "rounded terms changed under stall")

endmodule
